// File: hw/rtl/dpkm_pkg.sv
// Shared types, codes and address decode for the dual adapter keyboard block.
`timescale 1ns / 1ps
`default_nettype none
package dpkm_pkg;

   localparam logic [1:0] OP_BUS_READ  = 2'd0;
   localparam logic [1:0] OP_BUS_WRITE = 2'd1;
   localparam logic [1:0] OP_SET_KEY   = 2'd2;
   localparam logic [1:0] OP_SCAN      = 2'd3;

   localparam logic [15:0] ADDR_PIA1_A = 16'hFF00;
   localparam logic [15:0] ADDR_PIA1_B = 16'hFF02;
   localparam logic [15:0] ADDR_PIA2_A = 16'hFF20;
   localparam logic [15:0] ADDR_PIA2_B = 16'hFF22;

   localparam logic [1:0] PORT_PIA1_A = 2'd0;
   localparam logic [1:0] PORT_PIA1_B = 2'd1;
   localparam logic [1:0] PORT_PIA2_A = 2'd2;
   localparam logic [1:0] PORT_PIA2_B = 2'd3;

   localparam int CTRL_DATA_SELECT = 2;
   localparam int PORT_COUNT = 4;
   localparam int MATRIX_SIZE = 8;

   typedef struct packed {
      logic load;
      logic execute;
   } dpkm_cmd_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] port;
      logic       is_control;
   } dpkm_decode_type;

   function automatic dpkm_decode_type decode_address(input logic [15:0] address);
      dpkm_decode_type d;
      d.hit = 1'b1;
      d.is_control = address[0];
      if (address[15:1] == ADDR_PIA1_A[15:1]) begin
         d.port = PORT_PIA1_A;
      end else if (address[15:1] == ADDR_PIA1_B[15:1]) begin
         d.port = PORT_PIA1_B;
      end else if (address[15:1] == ADDR_PIA2_A[15:1]) begin
         d.port = PORT_PIA2_A;
      end else if (address[15:1] == ADDR_PIA2_B[15:1]) begin
         d.port = PORT_PIA2_B;
      end else begin
         d.port = PORT_PIA1_A;
         d.hit = 1'b0;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dpkm_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module dpkm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_strobe,
   output dpkm_pkg::dpkm_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_EXEC);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule
`default_nettype wire

// File: hw/rtl/dpkm_datapath.sv
// Datapath with the port registers, key map, bus decode and matrix scan.
`timescale 1ns / 1ps
`default_nettype none
module dpkm_datapath #(
   parameter int KEY_COUNT = 56
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dpkm_pkg::dpkm_cmd_type cmd,
   input  wire logic [1:0]            req_operation,
   input  wire logic [15:0]           req_address,
   input  wire logic [7:0]            req_write_data,
   input  wire logic [5:0]            req_key_index,
   input  wire logic                  req_key_pressed,
   output logic [7:0]                 rsp_read_data
);

   logic [1:0]  operation_ff;
   logic [15:0] address_ff;
   logic [7:0]  write_data_ff;
   logic [5:0]  key_index_ff;
   logic        key_pressed_ff;

   logic [7:0] port_data_ff [dpkm_pkg::PORT_COUNT];
   logic [7:0] port_direction_ff [dpkm_pkg::PORT_COUNT];
   logic [7:0] port_control_ff [dpkm_pkg::PORT_COUNT];
   logic [KEY_COUNT-1:0] key_down_ff;
   logic [7:0] result_ff;

   dpkm_pkg::dpkm_decode_type dec;
   logic [7:0] bus_value;
   logic [7:0] strobed;
   logic [7:0] rows;
   logic       bus_write_en;
   logic [1:0] write_port;
   logic       write_control;
   logic [7:0] write_value;

   always_comb begin
      dec = dpkm_pkg::decode_address(address_ff);
      if (!dec.hit) begin
         bus_value = 8'h00;
      end else if (dec.is_control) begin
         bus_value = port_control_ff[dec.port];
      end else if (port_control_ff[dec.port][dpkm_pkg::CTRL_DATA_SELECT]) begin
         bus_value = port_data_ff[dec.port];
      end else begin
         bus_value = port_direction_ff[dec.port];
      end
   end

   always_comb begin
      if (port_control_ff[dpkm_pkg::PORT_PIA1_B][dpkm_pkg::CTRL_DATA_SELECT]) begin
         strobed = ~port_data_ff[dpkm_pkg::PORT_PIA1_B];
      end else begin
         strobed = ~port_direction_ff[dpkm_pkg::PORT_PIA1_B];
      end
      rows = 8'hFF;
      for (int r = 0; r < dpkm_pkg::MATRIX_SIZE; r++) begin
         for (int c = 0; c < dpkm_pkg::MATRIX_SIZE; c++) begin
            if (r * dpkm_pkg::MATRIX_SIZE + c < KEY_COUNT) begin
               if (strobed[c] && key_down_ff[r * dpkm_pkg::MATRIX_SIZE + c]) begin
                  rows[r] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      bus_write_en = 1'b0;
      write_port = dec.port;
      write_control = dec.is_control;
      write_value = write_data_ff;
      if (cmd.execute) begin
         priority if (operation_ff == dpkm_pkg::OP_BUS_WRITE) begin
            bus_write_en = dec.hit;
         end else if (operation_ff == dpkm_pkg::OP_SCAN) begin
            bus_write_en = 1'b1;
            write_port = dpkm_pkg::PORT_PIA1_A;
            write_control = 1'b0;
            write_value = rows;
         end else begin
            bus_write_en = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         operation_ff <= req_operation;
         address_ff <= req_address;
         write_data_ff <= req_write_data;
         key_index_ff <= req_key_index;
         key_pressed_ff <= req_key_pressed;
      end
      if (cmd.execute) begin
         result_ff <= (operation_ff == dpkm_pkg::OP_BUS_READ) ? bus_value : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < dpkm_pkg::PORT_COUNT; p++) begin
            port_data_ff[p] <= 8'h00;
            port_direction_ff[p] <= 8'h00;
            port_control_ff[p] <= 8'h00;
         end
         key_down_ff <= '0;
      end else begin
         if (bus_write_en) begin
            if (write_control) begin
               port_control_ff[write_port] <= write_value;
            end else if (port_control_ff[write_port][dpkm_pkg::CTRL_DATA_SELECT]) begin
               port_data_ff[write_port] <= write_value;
            end else begin
               port_direction_ff[write_port] <= write_value;
            end
         end
         if (cmd.execute && operation_ff == dpkm_pkg::OP_SET_KEY) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
               if (key_index_ff == k[5:0]) begin
                  key_down_ff[k] <= key_pressed_ff;
               end
            end
         end
      end
   end

   assign rsp_read_data = result_ff;

endmodule
`default_nettype wire

// File: hw/rtl/dual_pia_with_keyboard_matrix_unit.sv
// Top level of the dual adapter block with keyboard matrix scanning.
// A request accepted at one edge is executed in the next cycle by the datapath,
// and its result is strobed for one cycle in the cycle after that.
// The controller does not accept a new request while in its execute state;
// a new request may be accepted while the previous result is strobed.
// Synchronous reset clears all port registers and releases every key.
`timescale 1ns / 1ps
`default_nettype none
module dual_pia_with_keyboard_matrix_unit #(
   parameter int KEY_COUNT = 56
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [5:0]  req_key_index,
   input  wire logic        req_key_pressed,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_read_data
);

   dpkm_pkg::dpkm_cmd_type cmd;

   dpkm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   dpkm_datapath #(
      .KEY_COUNT (KEY_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_key_index   (req_key_index),
      .req_key_pressed (req_key_pressed),
      .rsp_read_data   (rsp_read_data)
   );

endmodule
`default_nettype wire

// File: hw/rtl/dpkm_checker.sv
// Port-level checker for the dual adapter block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module dpkm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not make the block busy.");

   a_busy_then_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("Result was not strobed right after execution.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe lasted more than one cycle.");

   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result strobed without a request in execution.");

endmodule

bind dual_pia_with_keyboard_matrix_unit dpkm_checker u_dpkm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
`default_nettype wire
